FILE: hdl/wpr_pkg.sv
// package for the williams %r oscillator core
// holds sizing constants, status codes and the sequencer state type
// no dependencies
package wpr_pkg;

  localparam int MAX_WINDOW_DEF = 64;
  localparam int PRICE_W        = 32;
  localparam int CFG_W          = 7;
  localparam int PCT_W          = 16;
  localparam int STATUS_W       = 2;
  localparam int MAG_W          = 15;
  localparam int PROD_W         = PRICE_W + MAG_W;

  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd14;
  localparam logic [MAG_W-1:0] SCALE_Q8     = 15'd25600;

  localparam logic [STATUS_W-1:0] STATUS_VALID   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FILLING = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

FILE: hdl/williams_percent_r_core.sv
// williams %r oscillator core: window scan, scaling multiply and serial divider
// depends on wpr_pkg
//
// usage
// - input channel in_valid / in_stall carries one price word (high, low, close)
//   per bar; in_stall is high while a bar is being worked on
// - result channel out_valid / out_stall carries percent_r (q8, signed) and
//   status; a finished word waits in the output register while out_stall is
//   high, and the next bar is taken meanwhile
// - cfg_valid / cfg_ready writes window_length; write it only while idle
// - while the window is filling, a bar goes from the accept cycle straight to
//   hand-off; otherwise it passes through accept, window scan, check, multiply,
//   15 divider steps and hand-off
// - a window of 1 skips the scan; a flat range or a close outside the open
//   range skips multiply and divide
// - the history memory and its single read port set the scan length, one
//   entry per cycle; the divider retires one quotient bit per cycle
// - reset (synchronous, rst_n low) clears the write slot, the bar count and
//   the output valid flag, and sets the window length to 14; history contents
//   are not cleared and need no clearing pass
// - when the receiver stalls, the finished word is held and the core waits
//   in its hand-off state until the output register frees up
module williams_percent_r_core #(
  parameter int MAX_WINDOW = wpr_pkg::MAX_WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wpr_pkg::PRICE_W-1:0]   in_bar_high,
  input  logic [wpr_pkg::PRICE_W-1:0]   in_bar_low,
  input  logic [wpr_pkg::PRICE_W-1:0]   in_bar_close,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [wpr_pkg::PCT_W-1:0] out_percent_r,
  output logic [wpr_pkg::STATUS_W-1:0]  out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wpr_pkg::CFG_W-1:0]     cfg_window_length
);
  import wpr_pkg::*;

  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W  = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  localparam int DCNT_W = $clog2(MAG_W);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]   window_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [LEN_W-1:0]   bars_r;
  logic [LEN_W-1:0]   issue_cnt_r;
  logic [SLOT_W-1:0]  rd_idx_r;
  logic               rd_pend_r;
  logic [DCNT_W-1:0]  div_cnt_r;

  logic [PRICE_W-1:0] hh_r, ll_r, cl_r, diff_r, den_r, rem_r;
  logic [MAG_W-1:0]   low_r, mag_r;
  logic [STATUS_W-1:0] stat_r;

  logic [PRICE_W-1:0] high_mem [MAX_WINDOW];
  logic [PRICE_W-1:0] low_mem  [MAX_WINDOW];
  logic [PRICE_W-1:0] rd_hi_r, rd_lo_r;

  logic                out_valid_r;
  logic signed [PCT_W-1:0] out_pct_r;
  logic [STATUS_W-1:0] out_stat_r;

  // combinational helpers
  logic [CMP_W-1:0]   win_ext;
  logic [LEN_W-1:0]   len_eff;
  logic [LEN_W-1:0]   bars_nxt;
  logic               filling;
  logic               accept;
  logic               rd_issue;
  logic               load_out;
  logic [PRICE_W:0]   rem_sh;
  logic               div_ge;
  logic [PROD_W-1:0]  prod;
  logic [SLOT_W-1:0]  slot_prev;
  logic [SLOT_W-1:0]  rd_idx_dec;

  // effective window length and bar count
  always_comb begin
    win_ext = CMP_W'(window_r);
    if (window_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (win_ext > CMP_W'(MAX_WINDOW)) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = LEN_W'(win_ext);
    end
    if (bars_r < LEN_W'(MAX_WINDOW)) begin
      bars_nxt = bars_r + 1'b1;
    end else begin
      bars_nxt = bars_r;
    end
    filling = bars_nxt < len_eff;
  end

  always_comb begin
    slot_prev  = (slot_r == '0) ? SLOT_W'(MAX_WINDOW - 1) : slot_r - 1'b1;
    rd_idx_dec = (rd_idx_r == '0) ? SLOT_W'(MAX_WINDOW - 1) : rd_idx_r - 1'b1;
    rem_sh     = {rem_r, low_r[MAG_W-1]};
    div_ge     = rem_sh >= {1'b0, den_r};
    prod       = PROD_W'(diff_r) * PROD_W'(SCALE_Q8);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (filling) begin
            state_nxt = ST_DONE;
          end else if (len_eff == LEN_W'(1)) begin
            state_nxt = ST_CHECK;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (issue_cnt_r == '0 && !rd_pend_r) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (hh_r <= ll_r || cl_r >= hh_r || cl_r <= ll_r) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_cnt_r == DCNT_W'(MAG_W - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    accept   = (state_r == ST_IDLE) && in_valid;
    rd_issue = (state_r == ST_SCAN) && (issue_cnt_r != '0);
    load_out = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (cfg_valid) begin
      window_r <= cfg_window_length;
    end
  end

  // history memory
  always_ff @(posedge clk) begin
    if (accept) begin
      high_mem[slot_r] <= in_bar_high;
      low_mem[slot_r]  <= in_bar_low;
    end
    rd_hi_r <= high_mem[rd_idx_r];
    rd_lo_r <= low_mem[rd_idx_r];
  end

  // slot and bar count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      bars_r <= '0;
    end else if (accept) begin
      slot_r <= (slot_r == SLOT_W'(MAX_WINDOW - 1)) ? '0 : slot_r + 1'b1;
      bars_r <= bars_nxt;
    end
  end

  // scan sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r   <= 1'b0;
      issue_cnt_r <= '0;
    end else if (accept) begin
      rd_pend_r   <= 1'b0;
      issue_cnt_r <= len_eff - 1'b1;
    end else begin
      rd_pend_r <= rd_issue;
      if (rd_issue) begin
        issue_cnt_r <= issue_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_idx_r <= slot_prev;
    end else if (rd_issue) begin
      rd_idx_r <= rd_idx_dec;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      hh_r   <= in_bar_high;
      ll_r   <= in_bar_low;
      cl_r   <= in_bar_close;
      stat_r <= STATUS_FILLING;
      mag_r  <= '0;
    end
    if (state_r == ST_SCAN && rd_pend_r) begin
      if (rd_hi_r > hh_r) begin
        hh_r <= rd_hi_r;
      end
      if (rd_lo_r < ll_r) begin
        ll_r <= rd_lo_r;
      end
    end
    if (state_r == ST_CHECK) begin
      diff_r <= hh_r - cl_r;
      den_r  <= hh_r - ll_r;
      priority if (hh_r <= ll_r) begin
        stat_r <= STATUS_RANGE;
        mag_r  <= '0;
      end else if (cl_r >= hh_r) begin
        stat_r <= STATUS_VALID;
        mag_r  <= '0;
      end else if (cl_r <= ll_r) begin
        stat_r <= STATUS_VALID;
        mag_r  <= SCALE_Q8;
      end else begin
        stat_r <= STATUS_VALID;
      end
    end
    if (state_r == ST_MUL) begin
      rem_r     <= prod[PROD_W-1:MAG_W];
      low_r     <= prod[MAG_W-1:0];
      div_cnt_r <= '0;
    end
    if (state_r == ST_DIV) begin
      rem_r     <= div_ge ? PRICE_W'(rem_sh - {1'b0, den_r}) : rem_sh[PRICE_W-1:0];
      low_r     <= {low_r[MAG_W-2:0], 1'b0};
      mag_r     <= {mag_r[MAG_W-2:0], div_ge};
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pct_r  <= PCT_W'(0) - PCT_W'(mag_r);
      out_stat_r <= stat_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_percent_r = out_pct_r;
  assign out_status    = out_stat_r;

endmodule

FILE: tb/sv/williams_percent_r_core_tb.sv
// testbench for williams_percent_r_core: drives price bars, checks %r and status words
// against an in-bench window predictor; depends on wpr_pkg and williams_percent_r_core
module williams_percent_r_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wpr_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES = 150;
  localparam int RANDOM_BARS = 750;

  typedef struct packed {
    logic signed [PCT_W-1:0] percent_r;
    logic [STATUS_W-1:0] status;
  } wpr_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PRICE_W-1:0] in_bar_high = '0;
  logic [PRICE_W-1:0] in_bar_low = '0;
  logic [PRICE_W-1:0] in_bar_close = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [PCT_W-1:0] out_percent_r;
  logic [STATUS_W-1:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_window_length = '0;

  logic [PRICE_W-1:0] hist_high [MAX_WINDOW_DEF];
  logic [PRICE_W-1:0] hist_low [MAX_WINDOW_DEF];
  int unsigned next_slot = 0;
  int unsigned bar_count = 0;
  logic [CFG_W-1:0] window_reg = WINDOW_RESET;
  wpr_word_t pending_words[$];
  int failures = 0;
  bit calm = 1'b0;

  williams_percent_r_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_bar_high(in_bar_high),
    .in_bar_low(in_bar_low),
    .in_bar_close(in_bar_close),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_percent_r(out_percent_r),
    .out_status(out_status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_window_length(cfg_window_length)
  );

  always #6 clk = ~clk;

  function automatic wpr_word_t predict_percent_r(logic [PRICE_W-1:0] hi,
                                                  logic [PRICE_W-1:0] lo,
                                                  logic [PRICE_W-1:0] cl);
    wpr_word_t w;
    int unsigned len;
    int unsigned slot;
    int unsigned idx;
    logic [PRICE_W-1:0] hh;
    logic [PRICE_W-1:0] ll;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] mag;
    len = (window_reg == 0) ? 1 :
          (window_reg > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : int'(window_reg);
    slot = next_slot;
    hist_high[slot] = hi;
    hist_low[slot] = lo;
    next_slot = (slot + 1) % MAX_WINDOW_DEF;
    if (bar_count < MAX_WINDOW_DEF) begin
      bar_count++;
    end
    w.percent_r = '0;
    w.status = STATUS_FILLING;
    if (bar_count < len) begin
      return w;
    end
    hh = '0;
    ll = '1;
    for (int k = 0; k < len; k++) begin
      idx = (slot + MAX_WINDOW_DEF - k) % MAX_WINDOW_DEF;
      if (hist_high[idx] > hh) begin
        hh = hist_high[idx];
      end
      if (hist_low[idx] < ll) begin
        ll = hist_low[idx];
      end
    end
    if (hh <= ll) begin
      w.status = STATUS_RANGE;
      return w;
    end
    if (cl >= hh) begin
      mag = '0;
    end else if (cl <= ll) begin
      mag = 64'(SCALE_Q8);
    end else begin
      num = hh - cl;
      den = hh - ll;
      mag = (num * 64'(SCALE_Q8)) / den;
    end
    w.percent_r = PCT_W'(64'd0 - mag);
    w.status = STATUS_VALID;
    return w;
  endfunction

  task automatic send_bar(input logic [PRICE_W-1:0] hi, input logic [PRICE_W-1:0] lo,
                          input logic [PRICE_W-1:0] cl);
    int gap;
    if (!calm && $urandom_range(0, 99) < 7) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 110) : $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_bar_high <= hi;
    in_bar_low <= lo;
    in_bar_close <= cl;
    do @(posedge clk); while (in_stall);
    pending_words.push_back(predict_percent_r(hi, lo, cl));
  endtask

  task automatic wait_all_words();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_window_length(input logic [CFG_W-1:0] len);
    wait_all_words();
    cfg_valid <= 1'b1;
    cfg_window_length <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    window_reg = len;
  endtask

  task automatic test_reset_window();
    send_bar(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_bar(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 11; i++) begin
      send_bar($urandom, $urandom, $urandom);
    end
    send_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678);
  endtask

  task automatic test_single_bar_window();
    write_window_length(7'd1);
    send_bar(32'd1000, 32'd1000, 32'd1000);
    send_bar(32'd10, 32'd20, 32'd15);
    send_bar(32'd200, 32'd100, 32'd300);
    send_bar(32'd200, 32'd100, 32'd50);
    send_bar(32'hFFFF_FFFF, 32'd0, 32'd1);
    send_bar(32'd3, 32'd0, 32'd1);
  endtask

  task automatic test_window_out_of_range();
    write_window_length(7'd0);
    send_bar(32'd7, 32'd3, 32'd5);
    // longer window after a short one reports filling again
    write_window_length(7'd127);
    send_bar(32'd900, 32'd100, 32'd400);
    send_bar(32'hFFFF_FFFE, 32'h0000_0001, 32'h8000_0000);
  endtask

  task automatic test_random_bars();
    int sent;
    int phase;
    int phase_len;
    longint base;
    int unsigned roll;
    int unsigned up;
    int unsigned down;
    logic [PRICE_W-1:0] hi;
    logic [PRICE_W-1:0] lo;
    logic [PRICE_W-1:0] cl;
    logic [CFG_W-1:0] len;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_BARS) begin
      case (phase)
        0: len = 7'd64;
        1: len = 7'd65;
        2: len = 7'd2;
        3: len = 7'd1;
        4: len = 7'd127;
        5: len = 7'd14;
        default: len = CFG_W'($urandom_range(0, 127));
      endcase
      write_window_length(len);
      base = longint'($urandom);
      phase_len = $urandom_range(40, 90);
      for (int i = 0; i < phase_len && sent < RANDOM_BARS; i++) begin
        calm = (sent >= 300 && sent < 420);
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
          hi = $urandom;
          lo = $urandom;
          cl = $urandom;
        end else begin
          base = base + longint'($urandom_range(0, 4000)) - 2000;
          if (base < (longint'(1) << 21)) begin
            base = longint'(1) << 21;
          end
          if (base > (longint'(1) << 32) - 1 - (longint'(1) << 21)) begin
            base = (longint'(1) << 32) - 1 - (longint'(1) << 21);
          end
          up = (roll < 17) ? 0 : $urandom_range(0, 1 << $urandom_range(0, 20));
          down = (roll < 17) ? 0 : $urandom_range(0, 1 << $urandom_range(0, 20));
          hi = PRICE_W'(base + up);
          lo = PRICE_W'(base - down);
          if (roll < 21) begin
            cl = hi + $urandom_range(0, 500);
          end else if (roll < 25) begin
            cl = lo - $urandom_range(0, 500);
          end else begin
            cl = lo + $urandom_range(0, hi - lo);
          end
        end
        send_bar(hi, lo, cl);
        sent++;
      end
      phase++;
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 7);
  end

  always @(posedge clk) begin : check_words
    wpr_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("unexpected result word: percent_r %0d status %0d", out_percent_r, out_status);
        failures++;
      end else begin
        want = pending_words.pop_front();
        if (out_percent_r !== want.percent_r) begin
          $error("percent_r mismatch: expected %0d, actual %0d", want.percent_r, out_percent_r);
          failures++;
        end
        if (out_status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_status);
          failures++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("williams_percent_r_core_tb failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_window();
    test_single_bar_window();
    test_window_out_of_range();
    test_random_bars();
    wait_all_words();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && pending_words.size() == 0) begin
      $display("williams_percent_r_core_tb passed");
    end else begin
      $display("williams_percent_r_core_tb failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/wpr_pkg.sv
hdl/williams_percent_r_core.sv
tb/sv/williams_percent_r_core_tb.sv
